@@ hdl/touch_cursor_session_tracker_defines.svh @@
// Assertion macros for the touch cursor session tracker.
// Clocked on clk_i, disabled while rst_ni is low.
`ifndef TOUCH_CURSOR_SESSION_TRACKER_DEFINES_SVH
`define TOUCH_CURSOR_SESSION_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define TCST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define TCST_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  `TCST_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define TCST_ASSERT(lbl, prop, msg)
`define TCST_ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif

`endif

@@ hdl/tcst_pkg.sv @@
package tcst_pkg;

  typedef enum logic [1:0] {
    ACT_SET   = 2'd0,
    ACT_ALIVE = 2'd1,
    ACT_END   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    EV_ADD    = 2'd0,
    EV_UPDATE = 2'd1,
    EV_REMOVE = 2'd2,
    EV_FULL   = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_SWEEP  = 4'b1000
  } state_e;

  localparam logic [1:0] CFG_SQUARE_MODE = 2'd0;
  localparam logic [1:0] CFG_ROUND_LIMIT = 2'd1;
  localparam logic [1:0] CFG_X_SCALE     = 2'd2;
  localparam logic [1:0] CFG_Y_SCALE     = 2'd3;

  localparam logic [15:0] SCALE_ONE = 16'd16384;
  localparam logic [15:0] HALF_POS  = 16'h8000;
  // one quarter in Q0.32: radius one half, squared
  localparam logic [32:0] RADIUS_SQ = 33'h0_4000_0000;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        session_id;
    logic [15:0]        x_pos;
    logic [15:0]        y_pos;
    logic signed [15:0] x_speed;
    logic signed [15:0] y_speed;
    logic signed [15:0] motion_accel;
  } item_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [31:0]        out_session;
    logic [17:0]        out_x;
    logic [17:0]        out_y;
    logic signed [15:0] out_x_speed;
    logic signed [15:0] out_y_speed;
    logic signed [15:0] out_accel;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [17:0] x;
    logic [17:0] y;
    logic        far;
  } coord_t;

endpackage

@@ hdl/touch_cursor_session_tracker.sv @@
// Touch cursor session tracker. Session IDs live in a single-port-read
// memory that is scanned one slot per clock. A set or alive beat keeps busy_o
// high through the scan and, for a set, the decide state after it; an
// end-of-alive beat through the sweep, and its remove results come out
// one per cycle at most while the sweep runs. Action code 3 is taken
// and dropped without raising busy_o. Every result is presented for exactly
// one cycle on res_valid_o and is not held: the receiver must take it then.
// The config channel is ready only while the block is idle and no beat is
// offered on start_i, so a write never lands under an item in flight.
// No clearing pass is needed after reset.
`include "touch_cursor_session_tracker_defines.svh"

module touch_cursor_session_tracker #(
  parameter int MAX_SESSIONS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  tcst_pkg::item_t   item_i,
  output logic              res_valid_o,
  output tcst_pkg::result_t res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);

  localparam int AW = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;
  localparam int CW = $clog2(MAX_SESSIONS + 1);
  localparam logic [CW-1:0] NCNT = CW'(MAX_SESSIONS);

  tcst_pkg::state_e  state_q, state_d;
  tcst_pkg::item_t   item_q;
  tcst_pkg::result_t res_q, res_d;
  tcst_pkg::coord_t  coord;
  logic              res_valid_q, res_valid_d;

  logic        sq_mode_q, round_q;
  logic [15:0] x_scale_q, y_scale_q;

  logic [MAX_SESSIONS-1:0] valid_q, valid_d;
  logic [MAX_SESSIONS-1:0] seen_q, seen_d;

  logic [CW-1:0] iss_q, iss_d;
  logic          chk_vld_q, chk_vld_d;
  logic [AW-1:0] chk_idx_q, chk_idx_d;
  logic          hit_q, hit_d;
  logic          free_fnd_q, free_fnd_d;
  logic [AW-1:0] free_q, free_d;
  logic          pend_q, pend_d;
  logic [31:0]   pend_id_q, pend_id_d;

  logic          accept;
  logic          ram_we, ram_re;
  logic [31:0]   ram_rdata;
  logic          id_match;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != tcst_pkg::S_IDLE);
  assign cfg_ready_o = !busy_o && !start_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  tcst_id_ram #(
    .DEPTH (MAX_SESSIONS),
    .AW    (AW)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_q),
    .wdata_i (item_q.session_id),
    .re_i    (ram_re),
    .raddr_i (iss_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  tcst_coord u_coord (
    .clk_i     (clk_i),
    .x_pos_i   (item_q.x_pos),
    .y_pos_i   (item_q.y_pos),
    .x_scale_i (x_scale_q),
    .y_scale_i (y_scale_q),
    .coord_o   (coord)
  );

  // read data belongs to chk_idx_q; only meaningful when that slot is valid
  assign id_match = valid_q[chk_idx_q] && (ram_rdata == item_q.session_id);

  always_comb begin
    state_d     = state_q;
    iss_d       = iss_q;
    chk_vld_d   = 1'b0;
    chk_idx_d   = chk_idx_q;
    hit_d       = hit_q;
    free_fnd_d  = free_fnd_q;
    free_d      = free_q;
    pend_d      = pend_q;
    pend_id_d   = pend_id_q;
    valid_d     = valid_q;
    seen_d      = seen_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    case (state_q)
      tcst_pkg::S_IDLE: begin
        if (accept) begin
          iss_d      = '0;
          hit_d      = 1'b0;
          free_fnd_d = 1'b0;
          pend_d     = 1'b0;
          case (item_i.action)
            tcst_pkg::ACT_SET,
            tcst_pkg::ACT_ALIVE: state_d = tcst_pkg::S_SCAN;
            tcst_pkg::ACT_END:   state_d = tcst_pkg::S_SWEEP;
            default:             state_d = tcst_pkg::S_IDLE;
          endcase
        end
      end

      tcst_pkg::S_SCAN: begin
        if (iss_q != NCNT) begin
          ram_re    = 1'b1;
          iss_d     = iss_q + CW'(1);
          chk_vld_d = 1'b1;
          chk_idx_d = iss_q[AW-1:0];
        end
        if (chk_vld_q) begin
          if (id_match) begin
            hit_d = 1'b1;
            if (item_q.action == tcst_pkg::ACT_ALIVE) begin
              seen_d[chk_idx_q] = 1'b1;
            end
          end
          if (!valid_q[chk_idx_q] && !free_fnd_q) begin
            free_fnd_d = 1'b1;
            free_d     = chk_idx_q;
          end
        end else if (iss_q == NCNT) begin
          state_d = (item_q.action == tcst_pkg::ACT_SET) ? tcst_pkg::S_DECIDE
                                                         : tcst_pkg::S_IDLE;
        end
      end

      tcst_pkg::S_DECIDE: begin
        state_d = tcst_pkg::S_IDLE;
        if (!(sq_mode_q && round_q && coord.far)) begin
          res_valid_d       = 1'b1;
          res_d.out_session = item_q.session_id;
          res_d.out_x       = sq_mode_q ? {2'b00, item_q.x_pos} : coord.x;
          res_d.out_y       = sq_mode_q ? {2'b00, item_q.y_pos} : coord.y;
          res_d.out_x_speed = item_q.x_speed;
          res_d.out_y_speed = item_q.y_speed;
          res_d.out_accel   = item_q.motion_accel;
          res_d.last        = 1'b1;
          if (hit_q) begin
            res_d.event_kind = tcst_pkg::EV_UPDATE;
          end else if (free_fnd_q) begin
            res_d.event_kind = tcst_pkg::EV_ADD;
            ram_we           = 1'b1;
            valid_d[free_q]  = 1'b1;
            seen_d[free_q]   = 1'b0;
          end else begin
            res_d.event_kind = tcst_pkg::EV_FULL;
          end
        end
      end

      tcst_pkg::S_SWEEP: begin
        if (iss_q != NCNT) begin
          ram_re    = 1'b1;
          iss_d     = iss_q + CW'(1);
          chk_vld_d = 1'b1;
          chk_idx_d = iss_q[AW-1:0];
        end
        // one remove is held back so the final one can carry last
        if (chk_vld_q) begin
          if (valid_q[chk_idx_q] && !seen_q[chk_idx_q]) begin
            valid_d[chk_idx_q] = 1'b0;
            if (pend_q) begin
              res_valid_d       = 1'b1;
              res_d             = '0;
              res_d.event_kind  = tcst_pkg::EV_REMOVE;
              res_d.out_session = pend_id_q;
            end
            pend_d    = 1'b1;
            pend_id_d = ram_rdata;
          end
        end else if (iss_q == NCNT) begin
          if (pend_q) begin
            res_valid_d       = 1'b1;
            res_d             = '0;
            res_d.event_kind  = tcst_pkg::EV_REMOVE;
            res_d.out_session = pend_id_q;
            res_d.last        = 1'b1;
          end
          pend_d  = 1'b0;
          seen_d  = '0;
          state_d = tcst_pkg::S_IDLE;
        end
      end

      default: state_d = tcst_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcst_pkg::S_IDLE;
      res_valid_q <= 1'b0;
      valid_q     <= '0;
      seen_q      <= '0;
      iss_q       <= '0;
      chk_vld_q   <= 1'b0;
      chk_idx_q   <= '0;
      hit_q       <= 1'b0;
      free_fnd_q  <= 1'b0;
      free_q      <= '0;
      pend_q      <= 1'b0;
      sq_mode_q   <= 1'b1;
      round_q     <= 1'b0;
      x_scale_q   <= tcst_pkg::SCALE_ONE;
      y_scale_q   <= tcst_pkg::SCALE_ONE;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      valid_q     <= valid_d;
      seen_q      <= seen_d;
      iss_q       <= iss_d;
      chk_vld_q   <= chk_vld_d;
      chk_idx_q   <= chk_idx_d;
      hit_q       <= hit_d;
      free_fnd_q  <= free_fnd_d;
      free_q      <= free_d;
      pend_q      <= pend_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          tcst_pkg::CFG_SQUARE_MODE: sq_mode_q <= cfg_data_i[0];
          tcst_pkg::CFG_ROUND_LIMIT: round_q   <= cfg_data_i[0];
          tcst_pkg::CFG_X_SCALE:     x_scale_q <= cfg_data_i;
          tcst_pkg::CFG_Y_SCALE:     y_scale_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    pend_id_q <= pend_id_d;
    if (accept) begin
      item_q <= item_i;
    end
  end

  `TCST_ASSERT_IMPLIES(a_res_src, res_valid_o,
    ($past(state_q) == tcst_pkg::S_DECIDE) || ($past(state_q) == tcst_pkg::S_SWEEP),
    "result beat outside decide or sweep")
  `TCST_ASSERT_IMPLIES(a_sweep_clr,
    ($past(state_q) == tcst_pkg::S_SWEEP) && (state_q == tcst_pkg::S_IDLE),
    seen_q == '0, "seen marks left after sweep")
  `TCST_ASSERT_IMPLIES(a_add_grows,
    res_valid_o && (res_o.event_kind == tcst_pkg::EV_ADD),
    $countones(valid_q) == $countones($past(valid_q)) + 1, "add beat without a new slot")

endmodule

@@ hdl/tcst_id_ram.sv @@
module tcst_id_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/tcst_coord.sv @@
module tcst_coord (
  input  logic                clk_i,
  input  logic [15:0]         x_pos_i,
  input  logic [15:0]         y_pos_i,
  input  logic [15:0]         x_scale_i,
  input  logic [15:0]         y_scale_i,
  output tcst_pkg::coord_t    coord_o
);

  logic [15:0] dx, dy;
  logic [31:0] x_prod, y_prod;
  logic [17:0] x_q, y_q;
  logic [31:0] dx_sq_q, dy_sq_q;
  logic [32:0] dist_sq;

  // distance from the center, magnitude only
  assign dx = x_pos_i[15] ? {1'b0, x_pos_i[14:0]} : (tcst_pkg::HALF_POS - x_pos_i);
  assign dy = y_pos_i[15] ? {1'b0, y_pos_i[14:0]} : (tcst_pkg::HALF_POS - y_pos_i);

  assign x_prod = 32'(x_pos_i) * 32'(x_scale_i);
  assign y_prod = 32'(y_pos_i) * 32'(y_scale_i);

  always_ff @(posedge clk_i) begin
    x_q     <= x_prod[31:14];
    y_q     <= y_prod[31:14];
    dx_sq_q <= 32'(dx) * 32'(dx);
    dy_sq_q <= 32'(dy) * 32'(dy);
  end

  assign dist_sq = {1'b0, dx_sq_q} + {1'b0, dy_sq_q};

  assign coord_o.x   = x_q;
  assign coord_o.y   = y_q;
  assign coord_o.far = (dist_sq > tcst_pkg::RADIUS_SQ);

endmodule

@@ verif/touch_cursor_session_tracker_tb.sv @@
// Session table model plus the queue of events it expects from the block.
class session_checker #(int SLOTS = 32);
  logic [31:0]       slot_id[SLOTS];
  bit                slot_live[SLOTS];
  bit                slot_seen[SLOTS];
  bit                square_mode = 1'b1;
  bit                round_limit = 1'b0;
  logic [15:0]       x_scale = tcst_pkg::SCALE_ONE;
  logic [15:0]       y_scale = tcst_pkg::SCALE_ONE;
  tcst_pkg::result_t pending_events[$];
  int                errors;

  task report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  function void set_register(logic [1:0] idx, logic [15:0] val);
    case (idx)
      tcst_pkg::CFG_SQUARE_MODE: square_mode = val[0];
      tcst_pkg::CFG_ROUND_LIMIT: round_limit = val[0];
      tcst_pkg::CFG_X_SCALE:     x_scale = val;
      tcst_pkg::CFG_Y_SCALE:     y_scale = val;
      default: ;
    endcase
  endfunction

  function void predict_events(tcst_pkg::item_t it);
    tcst_pkg::result_t ev;
    tcst_pkg::result_t removals[$];
    int                hit;
    int                free_slot;
    logic [31:0]       prod;
    logic [15:0]       dx;
    logic [15:0]       dy;
    logic [33:0]       rsq;
    logic [17:0]       px;
    logic [17:0]       py;
    ev = '0;
    hit = -1;
    free_slot = -1;
    case (it.action)
      tcst_pkg::ACT_SET: begin
        px = {2'b00, it.x_pos};
        py = {2'b00, it.y_pos};
        if (square_mode) begin
          if (round_limit) begin
            dx = (it.x_pos >= tcst_pkg::HALF_POS) ? it.x_pos - tcst_pkg::HALF_POS
                                                  : tcst_pkg::HALF_POS - it.x_pos;
            dy = (it.y_pos >= tcst_pkg::HALF_POS) ? it.y_pos - tcst_pkg::HALF_POS
                                                  : tcst_pkg::HALF_POS - it.y_pos;
            rsq = 34'(dx) * 34'(dx) + 34'(dy) * 34'(dy);
            // outside the circle: no event, table untouched
            if (rsq > 34'(tcst_pkg::RADIUS_SQ)) return;
          end
        end else begin
          prod = 32'(it.x_pos) * 32'(x_scale);
          px = prod[31:14];
          prod = 32'(it.y_pos) * 32'(y_scale);
          py = prod[31:14];
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i]) begin
            if (hit < 0 && slot_id[i] == it.session_id) hit = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (hit >= 0) begin
          ev.event_kind = tcst_pkg::EV_UPDATE;
        end else if (free_slot >= 0) begin
          ev.event_kind = tcst_pkg::EV_ADD;
          slot_id[free_slot] = it.session_id;
          slot_live[free_slot] = 1'b1;
          slot_seen[free_slot] = 1'b0;
        end else begin
          ev.event_kind = tcst_pkg::EV_FULL;
        end
        ev.out_session = it.session_id;
        ev.out_x = px;
        ev.out_y = py;
        ev.out_x_speed = it.x_speed;
        ev.out_y_speed = it.y_speed;
        ev.out_accel = it.motion_accel;
        ev.last = 1'b1;
        pending_events.push_back(ev);
      end
      tcst_pkg::ACT_ALIVE: begin
        for (int i = 0; i < SLOTS; i++)
          if (slot_live[i] && slot_id[i] == it.session_id) slot_seen[i] = 1'b1;
      end
      tcst_pkg::ACT_END: begin
        // sweep goes in slot order, not by ID
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i] && !slot_seen[i]) begin
            slot_live[i] = 1'b0;
            ev = '0;
            ev.event_kind = tcst_pkg::EV_REMOVE;
            ev.out_session = slot_id[i];
            removals.push_back(ev);
          end
          slot_seen[i] = 1'b0;
        end
        for (int i = 0; i < removals.size(); i++) begin
          ev = removals[i];
          ev.last = (i == removals.size() - 1);
          pending_events.push_back(ev);
        end
      end
      default: ;
    endcase
  endfunction

  task check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task check_event(tcst_pkg::result_t got);
    tcst_pkg::result_t want;
    if (pending_events.size() == 0) begin
      report_mismatch($sformatf("unexpected event for session %0h", got.out_session));
      return;
    end
    want = pending_events.pop_front();
    check_field("event_kind", 32'(got.event_kind), 32'(want.event_kind));
    check_field("out_session", got.out_session, want.out_session);
    check_field("out_x", 32'(got.out_x), 32'(want.out_x));
    check_field("out_y", 32'(got.out_y), 32'(want.out_y));
    check_field("out_x_speed", 32'(got.out_x_speed), 32'(want.out_x_speed));
    check_field("out_y_speed", 32'(got.out_y_speed), 32'(want.out_y_speed));
    check_field("out_accel", 32'(got.out_accel), 32'(want.out_accel));
    check_field("last", 32'(got.last), 32'(want.last));
  endtask
endclass

module touch_cursor_session_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 32;
  localparam int SETTLE_CYCLES = SLOTS + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 72;
  localparam int NUM_PHASES = 6;
  localparam int POOL_SIZE = 48;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  tcst_pkg::item_t   item_i;
  logic              res_valid_o;
  tcst_pkg::result_t res_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i;
  logic [15:0]       cfg_data_i;

  session_checker #(SLOTS) sb;
  logic [31:0] id_pool[POOL_SIZE];
  int          idle_pct;
  int          items_sent;
  int          idle_cycles;

  touch_cursor_session_tracker #(.MAX_SESSIONS(SLOTS)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .item_i     (item_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // results first: a result and a new beat can share an edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) sb.check_event(res_o);
      if (start_i && !busy_o) sb.predict_events(item_i);
      if (cfg_valid_i && cfg_ready_o) sb.set_register(cfg_index_i, cfg_data_i);
      if (res_valid_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic tcst_pkg::item_t make_item(logic [1:0] act, logic [31:0] sid,
                                                logic [15:0] x, logic [15:0] y,
                                                logic [15:0] xs, logic [15:0] ys,
                                                logic [15:0] ac);
    tcst_pkg::item_t it;
    it.action = act;
    it.session_id = sid;
    it.x_pos = x;
    it.y_pos = y;
    it.x_speed = xs;
    it.y_speed = ys;
    it.motion_accel = ac;
    return it;
  endfunction

  function automatic logic [15:0] pick_pos();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return tcst_pkg::HALF_POS;
      default: return 16'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat,
  // with start_i still high so back-to-back beats need no toggle.
  task automatic send_item(tcst_pkg::item_t it);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 40 : 3)) @(negedge clk_i);
    end
    item_i <= it;
    start_i <= 1'b1;
    while (busy_o) @(negedge clk_i);
    @(negedge clk_i);
    if (it.action != ACT_UNUSED) items_sent++;
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (sb.pending_events.size() != 0) @(negedge clk_i);
    // alive beats and dropped points leave no event behind
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, logic [15:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    while (!cfg_ready_o) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apply_setting(bit sq, bit rl, logic [15:0] xs, logic [15:0] ys);
    wait_idle();
    write_register(tcst_pkg::CFG_SQUARE_MODE, {15'd0, sq});
    write_register(tcst_pkg::CFG_ROUND_LIMIT, {15'd0, rl});
    write_register(tcst_pkg::CFG_X_SCALE, xs);
    write_register(tcst_pkg::CFG_Y_SCALE, ys);
    cfg_valid_i <= 1'b0;
  endtask

  // One touch frame: sets, the alive list, then end of list; a little noise mixed in.
  task automatic run_frame(int keep_pct);
    logic [31:0] live_ids[$];
    int          n_sets;
    n_sets = $urandom_range(1, 16);
    repeat (n_sets) begin
      if ($urandom_range(99) < 8)
        send_item(make_item(2'($urandom_range(3)), $urandom, 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom)));
      else
        send_item(make_item(tcst_pkg::ACT_SET, id_pool[$urandom_range(POOL_SIZE - 1)],
                            pick_pos(), pick_pos(), 16'($urandom), 16'($urandom),
                            16'($urandom)));
    end
    for (int k = 0; k < SLOTS; k++)
      if (sb.slot_live[k]) live_ids.push_back(sb.slot_id[k]);
    foreach (live_ids[k])
      if ($urandom_range(99) < keep_pct)
        send_item(make_item(tcst_pkg::ACT_ALIVE, live_ids[k], 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom)));
    if ($urandom_range(3) == 0)
      send_item(make_item(tcst_pkg::ACT_ALIVE, $urandom, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    send_item(make_item(tcst_pkg::ACT_END, $urandom, 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom)));
  endtask

  initial begin
    int phase_end;
    int keep_pct;
    sb = new();
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = tcst_pkg::CFG_SQUARE_MODE;
    cfg_data_i = '0;
    idle_cycles = 0;
    idle_pct = 0;
    items_sent = 0;
    foreach (id_pool[k]) id_pool[k] = $urandom;
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extremes, update, alive of known and unknown IDs, unused action
    send_item(make_item(tcst_pkg::ACT_SET, 32'h0, 16'h0000, 16'h0000, 16'h8000, 16'h8000,
                        16'h8000));
    send_item(make_item(tcst_pkg::ACT_SET, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF,
                        16'h7FFF, 16'h7FFF));
    send_item(make_item(tcst_pkg::ACT_SET, 32'h0, 16'h1234, 16'hABCD, 16'h0001, 16'hFFFF,
                        16'h0000));
    send_item(make_item(tcst_pkg::ACT_ALIVE, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    send_item(make_item(tcst_pkg::ACT_ALIVE, 32'h1234_5678, 16'h0, 16'h0, 16'h0, 16'h0,
                        16'h0));
    send_item(make_item(ACT_UNUSED, 32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(make_item(tcst_pkg::ACT_END, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    // higher ID lands in a lower slot: removal order is by slot
    send_item(make_item(tcst_pkg::ACT_SET, 32'd7, 16'h4000, 16'hC000, 16'h0010, 16'h0020,
                        16'h0030));
    send_item(make_item(tcst_pkg::ACT_SET, 32'd3, 16'hC000, 16'h4000, 16'hFFF0, 16'hFFE0,
                        16'hFFD0));
    send_item(make_item(tcst_pkg::ACT_END, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    send_item(make_item(tcst_pkg::ACT_END, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));

    // round limit: centre, exactly on the circle, corner, just outside
    apply_setting(1'b1, 1'b1, tcst_pkg::SCALE_ONE, tcst_pkg::SCALE_ONE);
    send_item(make_item(tcst_pkg::ACT_SET, 32'd11, tcst_pkg::HALF_POS, tcst_pkg::HALF_POS,
                        16'h0, 16'h0, 16'h0));
    send_item(make_item(tcst_pkg::ACT_SET, 32'd12, 16'h0000, tcst_pkg::HALF_POS, 16'h1,
                        16'h2, 16'h3));
    send_item(make_item(tcst_pkg::ACT_SET, 32'd13, 16'h0000, 16'h0000, 16'h1, 16'h2, 16'h3));
    send_item(make_item(tcst_pkg::ACT_SET, 32'd14, 16'h0000, 16'h8001, 16'h1, 16'h2, 16'h3));

    // largest aspect factors on the largest position
    apply_setting(1'b0, 1'b0, 16'hFFFF, 16'hFFFF);
    send_item(make_item(tcst_pkg::ACT_SET, 32'd11, 16'hFFFF, 16'hFFFF, 16'h5555, 16'hAAAA,
                        16'h0F0F));
    send_item(make_item(tcst_pkg::ACT_SET, 32'd15, 16'h0000, 16'h0000, 16'h0, 16'h0, 16'h0));
    send_item(make_item(tcst_pkg::ACT_END, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: apply_setting(1'b1, 1'b0, tcst_pkg::SCALE_ONE, tcst_pkg::SCALE_ONE);
        1: apply_setting(1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
        2: apply_setting(1'b0, 1'b0, 16'hFFFF, tcst_pkg::SCALE_ONE);
        3: apply_setting(1'b0, 1'b1, tcst_pkg::SCALE_ONE, 16'hFFFF);
        4: apply_setting(1'b0, 1'($urandom), 16'($urandom_range(16384, 65535)),
                         16'($urandom_range(16384, 65535)));
        default: apply_setting(1'b1, 1'b1, 16'($urandom_range(16384, 65535)),
                               16'($urandom_range(16384, 65535)));
      endcase
      case (ph % 4)
        1: idle_pct = 51;
        3: idle_pct = 34;
        default: idle_pct = 0;
      endcase
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) begin
        // mostly keep sessions alive so the table fills up and overflows
        case ($urandom_range(4))
          0, 1: keep_pct = 100;
          2, 3: keep_pct = 90;
          default: keep_pct = 40;
        endcase
        run_frame(keep_pct);
      end
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
